/* rtl/flow_vector_to_color_core_defines.svh */
// assertion macros used by the checker file
`ifndef FLOW_VECTOR_TO_COLOR_CORE_DEFINES_SVH
`define FLOW_VECTOR_TO_COLOR_CORE_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define FVC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fvc assertion failed");

// next-cycle implication, masked while reset is high
`define FVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fvc assertion failed");

// next-cycle implication that also runs during reset
`define FVC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("fvc assertion failed");

`endif

/* rtl/fvc_pkg.sv */
`default_nettype none
package fvc_pkg;

   localparam int WHEEL_ENTRIES      = 55;
   localparam int WHEEL_IDX_W        = $clog2(WHEEL_ENTRIES);
   localparam int ANGLE_ITER_DEFAULT = 16;
   localparam int ATAN_TABLE_LEN     = 24;
   localparam int SQRT_STEPS         = 17;
   localparam int CHANNELS           = 3;
   localparam int SCALE_RESET        = 4096;

   // channel codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam logic [7:0] WHEEL_RED [WHEEL_ENTRIES] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd213, 8'd170, 8'd128, 8'd85,
      8'd43, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd19, 8'd39, 8'd58,
      8'd78, 8'd98, 8'd117, 8'd137, 8'd156, 8'd176, 8'd196, 8'd215, 8'd235, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255};

   localparam logic [7:0] WHEEL_GREEN [WHEEL_ENTRIES] = '{
      8'd0, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd119, 8'd136, 8'd153,
      8'd170, 8'd187, 8'd204, 8'd221, 8'd238, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd232, 8'd209, 8'd186, 8'd163,
      8'd140, 8'd116, 8'd93, 8'd70, 8'd47, 8'd24, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

   localparam logic [7:0] WHEEL_BLUE [WHEEL_ENTRIES] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd63, 8'd127, 8'd191, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd213, 8'd170, 8'd128, 8'd85, 8'd43};

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURNS [ATAN_TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

   typedef struct packed {
      logic               valid;
      logic               last;
      logic               zero;      // vertical part is zero
      logic               zneg;      // horizontal part is negative
      logic               unit_mag;  // magnitude at most one
      logic signed [34:0] x;
      logic signed [34:0] y;
      logic [31:0]        acc;
      logic [34:0]        rem;
      logic [34:0]        res;
   } fvc_lane_type;

   function automatic logic [7:0] wheel_entry(input logic [1:0] ch,
                                              input logic [WHEEL_IDX_W-1:0] k);
      logic [7:0] w;
      case (ch)
         CH_RED:   w = WHEEL_RED[k];
         CH_GREEN: w = WHEEL_GREEN[k];
         CH_BLUE:  w = WHEEL_BLUE[k];
         default:  w = 8'd0;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

/* rtl/fvc_req_if.sv */
`default_nettype none
interface fvc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] flow_u;
   logic signed [15:0] flow_v;
   logic               last_pixel;

   modport source(output valid, flow_u, flow_v, last_pixel, input ready);
   modport sink(input valid, flow_u, flow_v, last_pixel, output ready);
endinterface
`default_nettype wire

/* rtl/fvc_rsp_if.sv */
`default_nettype none
interface fvc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_end;

   modport source(output valid, red, green, blue, frame_end, input ready);
   modport sink(input valid, red, green, blue, frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/flow_vector_to_color_core.sv */
// channel  | dir | handshake        | payload
// req_chan | in  | valid / ready    | flow_u, flow_v (Q12.4), last_pixel
// rsp_chan | out | valid / ready    | red, green, blue, frame_end
// csr_*    | in  | apb write / read | scale_reciprocal at byte 0
//
// one pixel enters per clock while the pipe is not halted; it passes the front
// stages, a chain of cordic / square-root cells and the blend stages
// the whole pipe advances together; it halts only while a result beat waits
// on rsp_chan, so req_chan.ready follows rsp_chan.ready through one gate
// reset (synchronous) clears every stage valid and sets the scale to one
`default_nettype none
module flow_vector_to_color_core import fvc_pkg::*; #(
   parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fvc_req_if.sink          req_chan,
   fvc_rsp_if.source        rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // one cell per cordic step or square-root bit, whichever needs more
   localparam int CHAIN_LEN = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;

   logic         pipe_en;
   logic [15:0]  scale_ff;
   logic         rsp_valid;
   fvc_lane_type chain [CHAIN_LEN + 1];

   // register file: a single register, upper half of the map reads zero
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 16'(SCALE_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         scale_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, scale_ff};

   // global advance: move unless the output beat is stuck
   assign pipe_en        = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = pipe_en;
   assign rsp_chan.valid = rsp_valid;

   // scaling, magnitude square, pre-rotation into the right half plane
   fvc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (req_chan.valid),
      .flow_u     (req_chan.flow_u),
      .flow_v     (req_chan.flow_v),
      .last_pixel (req_chan.last_pixel),
      .scale      (scale_ff),
      .lane_out   (chain[0])
   );

   // each cell does one angle step (if IDX < ANGLE_ITERATIONS) and one root bit (if IDX < SQRT_STEPS), then hands on
   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      fvc_cell #(
         .IDX              (i),
         .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .prev_lane (chain[i]),
         .lane_out  (chain[i + 1])
      );
   end

   // wheel lookup, interpolation and white / dim blend
   fvc_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .lane_in   (chain[CHAIN_LEN]),
      .out_valid (rsp_valid),
      .out_red   (rsp_chan.red),
      .out_green (rsp_chan.green),
      .out_blue  (rsp_chan.blue),
      .out_last  (rsp_chan.frame_end)
   );

endmodule
`default_nettype wire

/* rtl/fvc_cell.sv */
`default_nettype none
module fvc_cell import fvc_pkg::*; #(
   parameter int IDX              = 0,
   parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  var  fvc_lane_type prev_lane,
   output var  fvc_lane_type lane_out
);

   localparam int SQ_SHIFT = (IDX < SQRT_STEPS) ? 32 - 2 * IDX : 0;
   localparam int AT_IDX   = (IDX < ATAN_TABLE_LEN) ? IDX : 0;

   fvc_lane_type lane_ff, lane_in;
   logic signed [34:0] xs, ys;
   logic [34:0] sq_bit, trial;

   always_comb begin
      lane_in = prev_lane;
      xs      = prev_lane.x >>> IDX;
      ys      = prev_lane.y >>> IDX;
      sq_bit  = 35'd1 << SQ_SHIFT;
      trial   = prev_lane.res + sq_bit;
      // one rotation step toward the u axis
      if (IDX < ANGLE_ITERATIONS) begin
         if (!prev_lane.y[34]) begin
            lane_in.x   = prev_lane.x + ys;
            lane_in.y   = prev_lane.y - xs;
            lane_in.acc = prev_lane.acc + ATAN_TURNS[AT_IDX];
         end else begin
            lane_in.x   = prev_lane.x - ys;
            lane_in.y   = prev_lane.y + xs;
            lane_in.acc = prev_lane.acc - ATAN_TURNS[AT_IDX];
         end
      end
      // one result bit of the square root
      if (IDX < SQRT_STEPS) begin
         if (prev_lane.rem >= trial) begin
            lane_in.rem = prev_lane.rem - trial;
            lane_in.res = (prev_lane.res >> 1) + sq_bit;
         end else begin
            lane_in.res = prev_lane.res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule
`default_nettype wire

/* rtl/fvc_front.sv */
`default_nettype none
module fvc_front import fvc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic signed [15:0] flow_u,
   input  wire logic signed [15:0] flow_v,
   input  wire logic               last_pixel,
   input  wire logic [15:0]        scale,
   output var  fvc_lane_type       lane_out
);

   // stage a: scaling products
   logic               a_valid_ff, a_last_ff;
   logic signed [31:0] a_du_ff, a_dv_ff;
   logic signed [32:0] s_ext, du_full, dv_full;

   // stage b: magnitudes and pre-rotation
   fvc_lane_type b_lane_ff, b_lane_in;
   logic         b_big_ff, b_big_in;
   logic [16:0]  b_au_ff, b_av_ff;
   logic [31:0]  au, av;

   // stage c: squares
   fvc_lane_type c_lane_ff;
   logic         c_big_ff;
   logic [33:0]  c_squ_ff, c_sqv_ff;

   // stage d: sum and range check
   fvc_lane_type d_lane_ff, d_lane_in;
   logic [34:0]  sum;

   always_comb begin
      s_ext   = $signed({17'd0, scale});
      du_full = 33'(flow_u) * s_ext;
      dv_full = 33'(flow_v) * s_ext;
   end

   always_comb begin
      au        = a_du_ff[31] ? 32'(-a_du_ff) : 32'(a_du_ff);
      av        = a_dv_ff[31] ? 32'(-a_dv_ff) : 32'(a_dv_ff);
      b_big_in  = (au > 32'd65536) || (av > 32'd65536);
      b_lane_in = '0;
      b_lane_in.valid = a_valid_ff;
      b_lane_in.last  = a_last_ff;
      b_lane_in.zero  = (a_dv_ff == 32'sd0);
      b_lane_in.zneg  = a_du_ff[31];
      if (a_du_ff[31]) begin
         b_lane_in.x   = -35'(a_du_ff);
         b_lane_in.y   = -35'(a_dv_ff);
         b_lane_in.acc = 32'h8000_0000;
      end else begin
         b_lane_in.x   = 35'(a_du_ff);
         b_lane_in.y   = 35'(a_dv_ff);
         b_lane_in.acc = 32'd0;
      end
   end

   always_comb begin
      sum                = 35'(c_squ_ff) + 35'(c_sqv_ff);
      d_lane_in          = c_lane_ff;
      d_lane_in.unit_mag = !c_big_ff && (sum <= 35'h1_0000_0000);
      d_lane_in.rem      = d_lane_in.unit_mag ? sum : 35'd0;
      d_lane_in.res      = 35'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         b_lane_ff.valid <= 1'b0;
         c_lane_ff.valid <= 1'b0;
         d_lane_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         a_last_ff  <= last_pixel;
         a_du_ff    <= du_full[31:0];
         a_dv_ff    <= dv_full[31:0];
         b_lane_ff  <= b_lane_in;
         b_big_ff   <= b_big_in;
         b_au_ff    <= au[16:0];
         b_av_ff    <= av[16:0];
         c_lane_ff  <= b_lane_ff;
         c_big_ff   <= b_big_ff;
         c_squ_ff   <= 34'(b_au_ff) * 34'(b_au_ff);
         c_sqv_ff   <= 34'(b_av_ff) * 34'(b_av_ff);
         d_lane_ff  <= d_lane_in;
      end
   end

   assign lane_out = d_lane_ff;

endmodule
`default_nettype wire

/* rtl/fvc_blend.sv */
`default_nettype none
module fvc_blend import fvc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  var  fvc_lane_type lane_in,
   output logic              out_valid,
   output logic [7:0]        out_red,
   output logic [7:0]        out_green,
   output logic [7:0]        out_blue,
   output logic              out_last
);

   localparam logic [23:0] FULL = 24'(255 * 65536);

   // stage e: wheel position
   logic                   e_valid_ff, e_last_ff, e_small_ff;
   logic [16:0]            e_mag_ff;
   logic [WHEEL_IDX_W-1:0] e_k0_ff, e_k0_in, e_k1_ff, e_k1_in;
   logic [15:0]            e_f_ff;
   logic [31:0]            acc_rnd;
   logic [15:0]            turn;
   logic [21:0]            pos;

   // stage f: interpolated colors
   logic        f_valid_ff, f_last_ff, f_small_ff;
   logic [16:0] f_mag_ff;
   logic [23:0] f_c_ff [CHANNELS];
   logic [23:0] f_c_in [CHANNELS];

   // stage g: white blend product or dimmed color
   logic        g_valid_ff, g_last_ff, g_small_ff;
   logic [40:0] g_d_ff [CHANNELS];
   logic [7:0]  g_dim_ff [CHANNELS];
   logic [25:0] c3 [CHANNELS];

   // output stage
   logic        out_valid_ff, out_last_ff;
   logic [7:0]  out_ch_ff [CHANNELS];
   logic [7:0]  out_ch_in [CHANNELS];
   logic [41:0] d_up [CHANNELS];

   always_comb begin
      acc_rnd = lane_in.acc + 32'h0000_8000;
      if (lane_in.zero) begin
         turn = lane_in.zneg ? 16'h8000 : 16'h0000;
      end else begin
         turn = acc_rnd[31:16];
      end
      pos     = 22'(turn) * 22'(WHEEL_ENTRIES - 1);
      e_k0_in = pos[21:16];
      e_k1_in = (e_k0_in == WHEEL_IDX_W'(WHEEL_ENTRIES - 1)) ? '0 : e_k0_in + 1'b1;
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         f_c_in[ch] = 24'((25'h1_0000 - 25'(e_f_ff)) * 25'(wheel_entry(2'(ch), e_k0_ff))
                    + 25'(e_f_ff) * 25'(wheel_entry(2'(ch), e_k1_ff)));
         c3[ch]     = 26'(f_c_ff[ch]) * 26'd3;
         d_up[ch]   = 42'(g_d_ff[ch]) + 42'h0_FFFF_FFFF;
         out_ch_in[ch] = g_small_ff ? 8'(8'd255 - d_up[ch][39:32]) : g_dim_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff   <= lane_in.valid;
         f_valid_ff   <= e_valid_ff;
         g_valid_ff   <= f_valid_ff;
         out_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_last_ff  <= lane_in.last;
         e_small_ff <= lane_in.unit_mag;
         e_mag_ff   <= lane_in.unit_mag ? lane_in.res[16:0] : 17'h1_0000;
         e_k0_ff    <= e_k0_in;
         e_k1_ff    <= e_k1_in;
         e_f_ff     <= pos[15:0];
         f_last_ff  <= e_last_ff;
         f_small_ff <= e_small_ff;
         f_mag_ff   <= e_mag_ff;
         g_last_ff  <= f_last_ff;
         g_small_ff <= f_small_ff;
         out_last_ff <= g_last_ff;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            f_c_ff[ch]    <= f_c_in[ch];
            g_d_ff[ch]    <= 41'(f_mag_ff) * 41'(FULL - f_c_ff[ch]);
            g_dim_ff[ch]  <= c3[ch][25:18];
            out_ch_ff[ch] <= out_ch_in[ch];
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_last  = out_last_ff;
   assign out_red   = out_ch_ff[CH_RED];
   assign out_green = out_ch_ff[CH_GREEN];
   assign out_blue  = out_ch_ff[CH_BLUE];

endmodule
`default_nettype wire

/* rtl/fvc_checker.sv */
`default_nettype none
`include "flow_vector_to_color_core_defines.svh"
module fvc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_red,
   input wire logic [7:0] rsp_green,
   input wire logic [7:0] rsp_blue,
   input wire logic       rsp_frame_end,
   input wire logic       csr_pready
);

   `FVC_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)
   `FVC_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `FVC_ASSERT_IMPLY(a_pready_high, clock, reset, req_valid || !req_valid, csr_pready)
   `FVC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_red, rsp_green, rsp_blue, rsp_frame_end}))

endmodule

bind flow_vector_to_color_core fvc_checker u_fvc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_red       (rsp_chan.red),
   .rsp_green     (rsp_chan.green),
   .rsp_blue      (rsp_chan.blue),
   .rsp_frame_end (rsp_chan.frame_end),
   .csr_pready    (csr_pready)
);
`default_nettype wire
